>>> hdl/postfix_stack_evaluator_top_defines.svh
// Assertion macros shared by the postfix evaluator modules.
// Depends on signals named clock and reset in the module that uses them.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

// Clocked check, switched off while reset is high.
`define PSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hdl/pse_pkg.sv
// Shared types, widths and codes for the postfix evaluator.
// No dependencies; every other file but pse_ram and the macro header imports this package.
package pse_pkg;

   localparam int unsigned DATA_W              = 32;
   localparam int unsigned FUNC_W              = 3;
   localparam int unsigned STATUS_W            = 2;
   localparam int unsigned DEPTH_OUT_W         = 7;
   localparam int unsigned STACK_DEPTH_DEFAULT = 64;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_COMMIT
   } pse_state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic div_start;
      logic commit;
   } pse_cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_done;
      logic rsp_free;
   } pse_status_type;

endpackage

>>> hdl/pse_channels.sv
// Valid/ready channel interfaces for the token input and the result output.
// Depends on pse_pkg for field widths.
interface pse_req_if;
   import pse_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] operand_value;

   modport source (output valid, output func, output operand_value, input ready);
   modport sink   (input valid, input func, input operand_value, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic [STATUS_W-1:0]      status;
   logic [DEPTH_OUT_W-1:0]   stack_depth;

   modport source (output valid, output top_value, output status, output stack_depth,
                   input ready);
   modport sink   (input valid, input top_value, input status, input stack_depth,
                   output ready);
endinterface

>>> hdl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/pse_divider.sv
// Signed 32-bit divider, truncating toward zero, one restoring step per cycle.
// Depends on pse_pkg for DATA_W.
module pse_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pse_pkg::DATA_W-1:0]   dividend,
   input  logic [pse_pkg::DATA_W-1:0]   divisor,
   output logic                         done,
   output logic [pse_pkg::DATA_W-1:0]   quotient
);
   import pse_pkg::*;

   localparam int unsigned CNT_W = $clog2(DATA_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] dvs_ff;
   logic              neg_ff;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (count_ff == CNT_W'(DATA_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= '0;
         rem_ff   <= '0;
         quo_ff   <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
         dvs_ff   <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
         neg_ff   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         count_ff <= count_ff + CNT_W'(1);
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff;

endmodule

>>> hdl/pse_controller.sv
// Sequencer for the postfix evaluator: accept, load, divide, commit.
// Depends on pse_pkg and the assertion macro header.
`include "postfix_stack_evaluator_top_defines.svh"

module pse_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pse_pkg::pse_status_type st,
   output pse_pkg::pse_cmd_type    cmd
);
   import pse_pkg::*;

   pse_state_type state_ff;
   pse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = st.is_div ? ST_DIV : ST_COMMIT;
         end
         ST_DIV: begin
            if (st.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (st.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.load      = 1'b1;
            cmd.div_start = st.is_div;
         end
         ST_DIV: begin
         end
         ST_COMMIT: begin
            cmd.commit = st.rsp_free;
         end
         default: begin
         end
      endcase
   end

   `PSE_ASSERT(a_accept_then_load, cmd.accept |=> state_ff == ST_LOAD, "transfer not followed by load")
   `PSE_ASSERT(a_commit_needs_slot, cmd.commit |-> st.rsp_free, "commit with result slot busy")
   `PSE_ASSERT(a_div_waits, (state_ff == ST_DIV && !st.div_done) |=> state_ff == ST_DIV, "left divide early")

endmodule

>>> hdl/pse_datapath.sv
// Operand stack, cached top, arithmetic and the result register.
// Depends on pse_pkg, pse_ram, pse_divider and the assertion macro header.
`include "postfix_stack_evaluator_top_defines.svh"

module pse_datapath #(
   parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pse_pkg::pse_cmd_type             cmd,
   output pse_pkg::pse_status_type          st,
   input  logic [pse_pkg::FUNC_W-1:0]       req_func,
   input  logic [pse_pkg::DATA_W-1:0]       req_operand,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [pse_pkg::DATA_W-1:0]       rsp_value,
   output logic [pse_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pse_pkg::DEPTH_OUT_W-1:0]  rsp_depth
);
   import pse_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [FUNC_W-1:0]      func_ff;
   logic [DATA_W-1:0]      opnd_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [DATA_W-1:0]      top_ff;
   logic [DATA_W-1:0]      top_in;
   logic [DATA_W-1:0]      a_ff;
   logic [DATA_W-1:0]      res_ff;
   logic                   bzero_ff;
   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [DEPTH_OUT_W-1:0] rsp_depth_ff;

   logic [CNT_W-1:0]       cnt_m2;
   logic                   empty;
   logic                   short;
   logic                   full;
   logic [DATA_W-1:0]      rd_data;
   logic [DATA_W-1:0]      a_val;
   logic [DATA_W-1:0]      b_val;
   logic [DATA_W-1:0]      alu_res;
   logic                   div_done;
   logic [DATA_W-1:0]      div_quo;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [DATA_W-1:0]      mem_wdata;
   logic [DATA_W-1:0]      out_value;
   logic [STATUS_W-1:0]    out_status;

   assign cnt_m2 = cnt_ff - CNT_W'(2);
   assign empty  = (cnt_ff == '0);
   assign short  = (cnt_ff < CNT_W'(2));
   assign full   = (cnt_ff >= CNT_W'(STACK_DEPTH));

   // Second entry from the top is read on every transfer; the top lives in top_ff.
   pse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (cmd.accept),
      .raddr (cnt_m2[ADDR_W-1:0]),
      .rdata (rd_data)
   );

   // Missing operands read as all ones.
   assign a_val = short ? '1 : rd_data;
   assign b_val = empty ? '1 : top_ff;

   always_comb begin
      case (func_ff)
         FUNC_ADD: alu_res = a_val + b_val;
         FUNC_SUB: alu_res = a_val - b_val;
         default:  alu_res = a_val * b_val;
      endcase
   end

   pse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_val),
      .divisor  (b_val),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         opnd_ff <= req_operand;
      end
      if (cmd.load) begin
         a_ff     <= rd_data;
         res_ff   <= alu_res;
         bzero_ff <= (b_val == '0);
      end else if (div_done) begin
         res_ff <= bzero_ff ? '0 : div_quo;
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      top_in     = top_ff;
      mem_we     = 1'b0;
      mem_waddr  = cnt_ff[ADDR_W-1:0];
      mem_wdata  = opnd_ff;
      out_value  = top_ff;
      out_status = STATUS_OK;
      case (func_ff) inside
         FUNC_PUSH: begin
            if (!full) begin
               mem_we    = 1'b1;
               top_in    = opnd_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
               out_value = opnd_ff;
            end else begin
               out_status = STATUS_FULL;
            end
         end
         FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
            mem_we    = 1'b1;
            mem_wdata = res_ff;
            top_in    = res_ff;
            out_value = res_ff;
            if (short) begin
               cnt_in     = CNT_W'(1);
               mem_waddr  = '0;
               out_status = STATUS_UNDER;
            end else begin
               cnt_in    = cnt_ff - CNT_W'(1);
               mem_waddr = cnt_m2[ADDR_W-1:0];
               if (func_ff == FUNC_DIV && bzero_ff) out_status = STATUS_DIVZERO;
            end
         end
         FUNC_POP: begin
            if (empty) begin
               out_value  = '1;
               out_status = STATUS_UNDER;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
               top_in = a_ff;
            end
         end
         default: begin
            if (empty) out_value = '0;
         end
      endcase
      if (!cmd.commit) mem_we = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         top_ff        <= top_in;
         rsp_value_ff  <= out_value;
         rsp_status_ff <= out_status;
         rsp_depth_ff  <= DEPTH_OUT_W'(cnt_in);
      end
   end

   assign st.is_div   = (func_ff == FUNC_DIV);
   assign st.div_done = div_done;
   assign st.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = rsp_depth_ff;

   `PSE_ASSERT(a_commit_sets_valid, cmd.commit |=> rsp_valid_ff, "result not raised after commit")
   `PSE_ASSERT(a_count_bounded, cnt_ff <= CNT_W'(STACK_DEPTH), "entry count past stack depth")
   `PSE_ASSERT(a_count_on_commit, !cmd.commit |=> $stable(cnt_ff), "entry count moved without commit")

endmodule

>>> hdl/postfix_stack_evaluator_top.sv
// Top level of the postfix (RPN) stack evaluator.
// Depends on pse_pkg, pse_channels, pse_controller and pse_datapath.
//
//   Channel  Dir  Payload                            Transfer on
//   req_bus  in   func, operand_value                valid & ready
//   rsp_bus  out  top_value, status, stack_depth     valid & ready
//
// Push, pop, add, subtract, multiply and unused codes: the token passes through the
// load and commit states to the result register.
// Divide: the token passes through load, the 32-step divider and commit to the result register.
// One token is in flight at a time; the next is taken while a result waits.
// Reset clears the entry count and the sequencer; stack contents stay undefined.
// A stalled result holds in the output register; commit waits for its slot.
module postfix_stack_evaluator_top #(
   parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   pse_req_if.sink   req_bus,
   pse_rsp_if.source rsp_bus
);
   import pse_pkg::*;

   pse_cmd_type    cmd;
   pse_status_type st;
   logic [DATA_W-1:0] rsp_value;

   // Sequencer: owns the input ready and steps each token through its phases.
   pse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Stack storage, arithmetic and the output register.
   pse_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_func    (req_bus.func),
      .req_operand (req_bus.operand_value),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_bus.status),
      .rsp_depth   (rsp_bus.stack_depth)
   );

   assign rsp_bus.top_value = rsp_value;

endmodule

>>> tb/pse_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the postfix stack evaluator: watches both channels and
// predicts each result from the accepted tokens. Depends on pse_pkg and pse_channels.
module pse_result_checker (
   input  logic        clock,
   input  logic        reset,
   pse_req_if          req_mon,
   pse_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned awaiting
);
   import pse_pkg::*;

   localparam logic [DATA_W-1:0] MISSING_OPERAND = '1;
   localparam int unsigned       REPORT_LIMIT    = 10;
   localparam int unsigned       SLOT_W          = $clog2(STACK_DEPTH_DEFAULT);

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [STATUS_W-1:0]      status;
      logic [DEPTH_OUT_W-1:0]   stack_depth;
   } token_result_type;

   logic [DATA_W-1:0] operand_stack [STACK_DEPTH_DEFAULT];
   int unsigned       entry_count;
   token_result_type  pending_results [$];
   int unsigned       failures;
   int unsigned       results_seen;

   function automatic logic [DATA_W-1:0] take_operand(inout bit short);
      if (entry_count == 0) begin
         short = 1'b1;
         return MISSING_OPERAND;
      end
      entry_count--;
      return operand_stack[SLOT_W'(entry_count)];
   endfunction

   function automatic logic [DATA_W-1:0] top_of_stack();
      return (entry_count == 0) ? '0 : operand_stack[SLOT_W'(entry_count - 1)];
   endfunction

   // Magnitudes first, so that the most negative value over -1 wraps.
   function automatic logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] lhs,
                                                         logic [DATA_W-1:0] rhs);
      logic [DATA_W-1:0] mag_l;
      logic [DATA_W-1:0] mag_r;
      logic [DATA_W-1:0] quot;
      mag_l = lhs[DATA_W-1] ? -lhs : lhs;
      mag_r = rhs[DATA_W-1] ? -rhs : rhs;
      quot  = mag_l / mag_r;
      return (lhs[DATA_W-1] != rhs[DATA_W-1]) ? -quot : quot;
   endfunction

   function automatic token_result_type evaluate_token(logic [FUNC_W-1:0] func,
                                                       logic [DATA_W-1:0] operand);
      token_result_type  res;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] combined;
      bit                short;
      short      = 1'b0;
      res.status = STATUS_OK;
      case (func) inside
         FUNC_PUSH: begin
            if (entry_count < STACK_DEPTH_DEFAULT) begin
               operand_stack[SLOT_W'(entry_count)] = operand;
               entry_count++;
            end else begin
               res.status = STATUS_FULL;
            end
            res.top_value = top_of_stack();
         end
         FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
            rhs = take_operand(short);
            lhs = take_operand(short);
            case (func)
               FUNC_ADD: combined = lhs + rhs;
               FUNC_SUB: combined = lhs - rhs;
               FUNC_MUL: combined = lhs * rhs;
               default: begin
                  if (rhs == '0) begin
                     combined   = '0;
                     res.status = STATUS_DIVZERO;
                  end else begin
                     combined = trunc_quotient(lhs, rhs);
                  end
               end
            endcase
            if (short) res.status = STATUS_UNDER;
            operand_stack[SLOT_W'(entry_count)] = combined;
            entry_count++;
            res.top_value = top_of_stack();
         end
         FUNC_POP: begin
            res.top_value = take_operand(short);
            if (short) res.status = STATUS_UNDER;
         end
         default: res.top_value = top_of_stack();
      endcase
      res.stack_depth = entry_count[DEPTH_OUT_W-1:0];
      return res;
   endfunction

   task automatic note_failure();
      failures++;
   endtask

   always @(posedge clock) begin : watch
      token_result_type want;
      token_result_type got;
      if (reset) begin
         entry_count = 0;
         pending_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.top_value   = rsp_mon.top_value;
            got.status      = rsp_mon.status;
            got.stack_depth = rsp_mon.stack_depth;
            if (pending_results.size() == 0) begin
               note_failure();
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result %0d with none expected: top %0d status %0d depth %0d",
                           $realtime, results_seen, got.top_value, got.status,
                           got.stack_depth);
            end else begin
               want = pending_results.pop_front();
               if (got.top_value !== want.top_value || got.status !== want.status ||
                   got.stack_depth !== want.stack_depth) begin
                  note_failure();
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: result %0d: expected top %0d status %0d depth %0d, %s",
                              $realtime, results_seen, want.top_value, want.status,
                              want.stack_depth,
                              $sformatf("got top %0d status %0d depth %0d",
                                        got.top_value, got.status, got.stack_depth));
               end
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(evaluate_token(req_mon.func, req_mon.operand_value));
      end
      awaiting   <= unsigned'(pending_results.size());
      fail_count <= failures;
   end

   initial begin
      failures     = 0;
      results_seen = 0;
      entry_count  = 0;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the postfix stack evaluator testbench: clock, reset, token stimulus
// and verdict. Depends on pse_pkg, pse_channels, the evaluator RTL and pse_result_checker.
module tb;
   import pse_pkg::*;

   // Codes the block defines as no-ops; they must leave the stack alone.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

   localparam int unsigned PHASE_TOKENS = 300;
   localparam int unsigned DRAIN_CYCLES = 64;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned awaiting;

   // Idle and stall odds, in percent of cycles; changed per phase.
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned sent      = 0;
   // Rough copy of the stack depth, only to shape the stimulus.
   int unsigned depth_guess = 0;

   pse_req_if req_bus();
   pse_rsp_if rsp_bus();

   postfix_stack_evaluator_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pse_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: decide ready afresh at every edge, so stalls land on any cycle.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Hold off, present one token and wait for its transfer. Valid stays high
   // into the next token when no gap is drawn, so it is written once per step.
   task automatic send_token(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.func          <= func;
      req_bus.operand_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      case (func) inside
         FUNC_PUSH: if (depth_guess < STACK_DEPTH_DEFAULT) depth_guess++;
         FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV:
            depth_guess = (depth_guess >= 2) ? depth_guess - 1 : 1;
         FUNC_POP: if (depth_guess > 0) depth_guess--;
         default: ;
      endcase
      sent++;
   endtask

   // Bias operands towards the edges and towards zero divisors.
   function automatic logic [DATA_W-1:0] pick_operand();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 32'd1;
         2:       return ALL_ONES;
         3:       return MOST_POSITIVE;
         4:       return MOST_NEGATIVE;
         5, 6:    return $urandom_range(40) - 20;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_operator();
      case ($urandom_range(3))
         0:       return FUNC_ADD;
         1:       return FUNC_SUB;
         2:       return FUNC_MUL;
         default: return FUNC_DIV;
      endcase
   endfunction

   // Well-formed expression: operators only once two operands are there,
   // closed by a pop of the answer.
   task automatic run_expression();
      int unsigned length;
      length = $urandom_range(3, 15);
      repeat (length) begin
         if (depth_guess < 2 || ($urandom_range(99) < 45 && depth_guess < STACK_DEPTH_DEFAULT))
            send_token(FUNC_PUSH, pick_operand());
         else
            send_token(pick_operator(), $urandom());
      end
      send_token(FUNC_POP, $urandom());
   endtask

   // Fill the stack, push past the top, then fold a few entries back.
   task automatic run_climb();
      while (depth_guess < STACK_DEPTH_DEFAULT) begin
         if (depth_guess >= 2 && $urandom_range(9) == 0)
            send_token(pick_operator(), $urandom());
         else
            send_token(FUNC_PUSH, pick_operand());
      end
      repeat ($urandom_range(1, 3)) send_token(FUNC_PUSH, $urandom());
      repeat ($urandom_range(4)) send_token(pick_operator(), $urandom());
   endtask

   // Empty the stack and pop a little beyond it.
   task automatic run_drain();
      while (depth_guess > 0) send_token(FUNC_POP, $urandom());
      repeat ($urandom_range(2)) send_token(FUNC_POP, $urandom());
   endtask

   // Any code, any value, spare codes included.
   task automatic run_noise();
      repeat ($urandom_range(4, 10)) send_token(FUNC_W'($urandom_range(7)), $urandom());
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned pick;
      bit          first;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.func          <= FUNC_PUSH;
      req_bus.operand_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed tokens, back to back.
      send_token(FUNC_POP, '0);              // pop on an empty stack
      send_token(FUNC_ADD, '0);              // both operands missing
      send_token(FUNC_POP, ALL_ONES);
      send_token(FUNC_PUSH, 32'd7);
      send_token(FUNC_SUB, '0);              // left operand missing
      send_token(FUNC_POP, '0);
      send_token(FUNC_PUSH, MOST_POSITIVE);
      send_token(FUNC_PUSH, 32'd1);
      send_token(FUNC_ADD, '0);              // wraps to the most negative value
      send_token(FUNC_PUSH, ALL_ONES);
      send_token(FUNC_DIV, '0);              // most negative over -1
      send_token(FUNC_PUSH, '0);
      send_token(FUNC_DIV, '0);              // divide by zero
      send_token(FUNC_PUSH, -32'sd7);
      send_token(FUNC_PUSH, 32'd2);
      send_token(FUNC_DIV, '0);              // truncation toward zero
      send_token(FUNC_PUSH, 32'h9ABC_DEF0);
      send_token(FUNC_MUL, '0);
      send_token(FUNC_SUB, ALL_ONES);
      send_token(FUNC_SPARE_6, MOST_NEGATIVE);
      send_token(FUNC_SPARE_7, ALL_ONES);
      send_token(FUNC_POP, '0);
      send_token(FUNC_PUSH, '0);
      send_token(FUNC_DIV, '0);              // underflow beats divide by zero
      send_token(FUNC_POP, '0);

      // Random phases: none idle, sender idle, receiver stalls, both.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 48; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         first = 1'b1;
         while (sent < 25 + (phase + 1) * PHASE_TOKENS) begin
            pick = first ? 60 : $urandom_range(99);
            first = 1'b0;
            if (pick < 55)      run_expression();
            else if (pick < 65) run_climb();
            else if (pick < 80) run_drain();
            else                run_noise();
         end
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every expected result, then let the block settle.
      do @(posedge clock); while (awaiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
